### rtl/core/fbsc_pkg.sv
// fbsc_pkg: shared types and constants of the frustum box and sphere cull unit
package fbsc_pkg;

    // plane set
    localparam int NUM_PLANES   = 6;
    localparam int PLANE_W      = 64;
    localparam int PLANE_IDX_W  = 3;

    // operand widths
    localparam int COORD_W      = 16;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int FRAC_W       = 14;
    localparam int DIST_W       = PROD_W + 2;
    localparam int COUNT_W      = 8;
    localparam int TOTAL_W      = 32;

    // item operation codes
    localparam logic [1:0] OP_BOX    = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // control from the result stage to the running total
    typedef struct packed {
        logic       load;
        logic [1:0] op;
        logic       visible;
    } total_ctl_t;

endpackage

### rtl/core/frustum_box_sphere_cull.sv
// frustum_box_sphere_cull: top level, plane registers, pipeline and result beat
// Tests boxes and spheres against six clipping planes written through the
// configuration port (index 0..5: left, right, bottom, top, near, far; other
// indexes are ignored). The unit takes one beat per clock while in_stall is low
// and returns one result beat per input beat, in order, through an input
// register, a register behind the eighteen parallel 16x16 plane products, and
// the result register with the running total. Throughput is one item per cycle
// when the output is not stalled; the six plane multiply-add units set the clock
// path. Planes must be written while no item is in flight.
module frustum_box_sphere_cull
    import fbsc_pkg::*;
#(
    parameter int CLUSTER_MAX = 128
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [PLANE_IDX_W-1:0]      cfg_index,
    input  logic [PLANE_W-1:0]          cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  op,
    input  logic signed [COORD_W-1:0]   px,
    input  logic signed [COORD_W-1:0]   py,
    input  logic signed [COORD_W-1:0]   pz,
    input  logic signed [COORD_W-1:0]   qx,
    input  logic signed [COORD_W-1:0]   qy,
    input  logic signed [COORD_W-1:0]   qz,
    input  logic [COORD_W-1:0]          radius,
    input  logic [COUNT_W-1:0]          item_count,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        visible,
    output logic [TOTAL_W-1:0]          visible_total
);

    logic [PLANE_W-1:0]        plane_reg [NUM_PLANES];

    logic                      s1_valid_reg;
    logic [1:0]                s1_op_reg;
    logic signed [COORD_W-1:0] s1_px_reg;
    logic signed [COORD_W-1:0] s1_py_reg;
    logic signed [COORD_W-1:0] s1_pz_reg;
    logic signed [COORD_W-1:0] s1_qx_reg;
    logic signed [COORD_W-1:0] s1_qy_reg;
    logic signed [COORD_W-1:0] s1_qz_reg;
    logic [COORD_W-1:0]        s1_radius_reg;
    logic [COUNT_W-1:0]        s1_count_reg;

    logic                      s2_valid_reg;
    logic [1:0]                s2_op_reg;
    logic [COORD_W-1:0]        s2_radius_reg;
    logic [COORD_W-1:0]        s2_radius_next;
    logic [COUNT_W-1:0]        s2_count_reg;

    logic                      out_valid_reg;
    logic                      visible_reg;
    logic                      visible_next;

    logic                      out_ready;
    logic                      s2_ready;
    logic                      s1_ready;
    logic                      s1_is_box;
    logic [NUM_PLANES-1:0]     behind;
    total_ctl_t                total_ctl;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
                plane_reg[i] <= '0;
        end
        else if (cfg_wr_en && (32'(cfg_index) < NUM_PLANES))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // stage readiness, each stage loads when empty or draining
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_op_reg     <= op;
            s1_px_reg     <= px;
            s1_py_reg     <= py;
            s1_pz_reg     <= pz;
            s1_qx_reg     <= qx;
            s1_qy_reg     <= qy;
            s1_qz_reg     <= qz;
            s1_radius_reg <= radius;
            s1_count_reg  <= item_count;
        end
    end

    // plane products, a box is tested against zero margin
    assign s1_is_box      = (s1_op_reg == OP_BOX);
    assign s2_radius_next = s1_is_box ? '0 : s1_radius_reg;

    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_plane
        fbsc_plane_test u_plane (
            .clk    (clk),
            .load   (s2_ready && s1_valid_reg),
            .plane  (plane_reg[g]),
            .is_box (s1_is_box),
            .px     (s1_px_reg),
            .py     (s1_py_reg),
            .pz     (s1_pz_reg),
            .qx     (s1_qx_reg),
            .qy     (s1_qy_reg),
            .qz     (s1_qz_reg),
            .radius (s2_radius_reg),
            .behind (behind[g])
        );
    end

    // product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_radius_reg <= s2_radius_next;
            s2_count_reg  <= s1_count_reg;
        end
    end

    // visibility decision
    assign visible_next = ((s2_op_reg == OP_BOX) || (s2_op_reg == OP_SPHERE)) && !(|behind);

    // running total
    assign total_ctl.load    = out_ready && s2_valid_reg;
    assign total_ctl.op      = s2_op_reg;
    assign total_ctl.visible = visible_next;

    fbsc_total #(
        .CLUSTER_MAX (CLUSTER_MAX)
    ) u_total (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (total_ctl),
        .item_count (s2_count_reg),
        .total      (visible_total)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
                visible_reg <= visible_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

    // clear beat leaves a zero total and a culled flag
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready && s2_valid_reg && (s2_op_reg == OP_CLEAR))
        |=> (visible_total == '0) && !visible)
        else $error("clear beat did not zero the total");

    // only a clear can lower the total
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready && s2_valid_reg && (s2_op_reg != OP_CLEAR))
        |=> (visible_total >= $past(visible_total)))
        else $error("visible total decreased without a clear");

    // a box beat never changes the total
    a_box_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready && s2_valid_reg && (s2_op_reg == OP_BOX))
        |=> $stable(visible_total))
        else $error("box beat changed the visible total");

    // input is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a free pipeline stage");

endmodule

### rtl/core/fbsc_plane_test.sv
// fbsc_plane_test: one clipping plane, registered products and behind test
module fbsc_plane_test
    import fbsc_pkg::*;
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [PLANE_W-1:0]          plane,
    input  logic                        is_box,
    input  logic signed [COORD_W-1:0]   px,
    input  logic signed [COORD_W-1:0]   py,
    input  logic signed [COORD_W-1:0]   pz,
    input  logic signed [COORD_W-1:0]   qx,
    input  logic signed [COORD_W-1:0]   qy,
    input  logic signed [COORD_W-1:0]   qz,
    input  logic [COORD_W-1:0]          radius,
    output logic                        behind
);

    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] x_sel;
    logic signed [COORD_W-1:0] y_sel;
    logic signed [COORD_W-1:0] z_sel;
    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;
    logic signed [PROD_W-1:0]  prod_z_next;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [PROD_W-1:0]  prod_z_reg;
    logic signed [COORD_W-1:0] d_reg;
    logic signed [DIST_W-1:0]  d_scaled;
    logic signed [DIST_W-1:0]  rad_scaled;
    logic signed [DIST_W-1:0]  dist_sum;

    // plane fields
    assign nx = plane[COORD_W-1:0];
    assign ny = plane[2*COORD_W-1:COORD_W];
    assign nz = plane[3*COORD_W-1:2*COORD_W];

    // positive vertex for a box, center for a sphere
    assign x_sel = (is_box && !nx[COORD_W-1]) ? qx : px;
    assign y_sel = (is_box && !ny[COORD_W-1]) ? qy : py;
    assign z_sel = (is_box && !nz[COORD_W-1]) ? qz : pz;

    assign prod_x_next = nx * x_sel;
    assign prod_y_next = ny * y_sel;
    assign prod_z_next = nz * z_sel;

    // product register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            d_reg      <= plane[4*COORD_W-1:3*COORD_W];
        end
    end

    // distance plus radius, all in Q.14; negative means behind
    assign d_scaled   = DIST_W'(d_reg) <<< FRAC_W;
    assign rad_scaled = {{(DIST_W-COORD_W-FRAC_W){1'b0}}, radius, {FRAC_W{1'b0}}};
    assign dist_sum   = DIST_W'(prod_x_reg) + DIST_W'(prod_y_reg) + DIST_W'(prod_z_reg)
                      + d_scaled + rad_scaled;
    assign behind     = dist_sum[DIST_W-1];

endmodule

### rtl/core/fbsc_total.sv
// fbsc_total: saturating running count of visible instances
module fbsc_total
    import fbsc_pkg::*;
#(
    parameter int CLUSTER_MAX = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  total_ctl_t           ctl,
    input  logic [COUNT_W-1:0]   item_count,
    output logic [TOTAL_W-1:0]   total
);

    localparam logic [TOTAL_W-1:0] CNT_LIMIT = TOTAL_W'(CLUSTER_MAX);

    logic [TOTAL_W-1:0] cnt_ext;
    logic [TOTAL_W-1:0] cnt_clamped;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W-1:0] total_reg;

    // clamp and saturating add
    assign cnt_ext     = TOTAL_W'(item_count);
    assign cnt_clamped = (cnt_ext > CNT_LIMIT) ? CNT_LIMIT : cnt_ext;
    assign sum_wide    = {1'b0, total_reg} + {1'b0, cnt_clamped};

    always_comb
    begin
        total_next = total_reg;
        unique case (ctl.op)
            OP_SPHERE:
            begin
                if (ctl.visible)
                    total_next = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
            end
            OP_CLEAR:
                total_next = '0;
            default:
                total_next = total_reg;
        endcase
    end

    // total register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (ctl.load)
            total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

### tb/frustum_box_sphere_cull_checker.sv
// frustum_box_sphere_cull_checker: predicts and checks the result beats of the cull unit
`timescale 1ns / 100ps

module frustum_box_sphere_cull_checker
    import fbsc_pkg::*;
#(
    parameter int CLUSTER_MAX = 128
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [PLANE_IDX_W-1:0]      cfg_index,
    input  logic [PLANE_W-1:0]          cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [1:0]                  op,
    input  logic signed [COORD_W-1:0]   px,
    input  logic signed [COORD_W-1:0]   py,
    input  logic signed [COORD_W-1:0]   pz,
    input  logic signed [COORD_W-1:0]   qx,
    input  logic signed [COORD_W-1:0]   qy,
    input  logic signed [COORD_W-1:0]   qz,
    input  logic [COORD_W-1:0]          radius,
    input  logic [COUNT_W-1:0]          item_count,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        visible,
    input  logic [TOTAL_W-1:0]          visible_total,
    output int                          mismatches,
    output int                          pending_beats,
    output int                          checked_beats,
    output int                          culled_beats
);

    typedef struct packed {
        logic               visible;
        logic [TOTAL_W-1:0] total;
    } cull_beat_t;

    localparam longint Q14_SCALE = longint'(1) << FRAC_W;

    logic [PLANE_W-1:0] plane_regs [NUM_PLANES];
    logic [TOTAL_W-1:0] instance_total;
    cull_beat_t         expected_beats [$];

    // signed distance in Q.14, exact
    function automatic longint plane_distance(input logic [PLANE_W-1:0] plane,
                                              input longint x, input longint y,
                                              input longint z);
        return longint'($signed(plane[15:0])) * x
             + longint'($signed(plane[31:16])) * y
             + longint'($signed(plane[47:32])) * z
             + longint'($signed(plane[63:48])) * Q14_SCALE;
    endfunction

    // positive vertex per plane; a zero normal part picks the maximum
    function automatic logic box_in_view(input logic signed [COORD_W-1:0] lx, ly, lz,
                                         input logic signed [COORD_W-1:0] hx, hy, hz);
        logic   seen;
        longint cx, cy, cz;
        int     i;
        seen = 1'b1;
        for (i = 0; i < NUM_PLANES; i++)
        begin
            cx = plane_regs[i][15] ? longint'(lx) : longint'(hx);
            cy = plane_regs[i][31] ? longint'(ly) : longint'(hy);
            cz = plane_regs[i][47] ? longint'(lz) : longint'(hz);
            if (plane_distance(plane_regs[i], cx, cy, cz) < 0)
                seen = 1'b0;
        end
        return seen;
    endfunction

    // culled only when strictly beyond minus the radius
    function automatic logic sphere_in_view(input logic signed [COORD_W-1:0] cx, cy, cz,
                                            input logic [COORD_W-1:0] rad);
        logic   seen;
        longint limit;
        int     i;
        seen  = 1'b1;
        limit = -(longint'(rad) * Q14_SCALE);
        for (i = 0; i < NUM_PLANES; i++)
            if (plane_distance(plane_regs[i], longint'(cx), longint'(cy),
                               longint'(cz)) < limit)
                seen = 1'b0;
        return seen;
    endfunction

    // one item: visibility and the running total after it
    function automatic cull_beat_t cull_item(input logic [1:0] kind,
                                             input logic signed [COORD_W-1:0] ax, ay, az,
                                             input logic signed [COORD_W-1:0] bx, by, bz,
                                             input logic [COORD_W-1:0] rad,
                                             input logic [COUNT_W-1:0] cnt);
        cull_beat_t  beat;
        int unsigned add;
        logic [63:0] wide;
        beat.visible = 1'b0;
        case (kind)
            OP_BOX:
                beat.visible = box_in_view(ax, ay, az, bx, by, bz);
            OP_SPHERE:
            begin
                beat.visible = sphere_in_view(ax, ay, az, rad);
                if (beat.visible)
                begin
                    add  = (cnt > CLUSTER_MAX) ? CLUSTER_MAX : cnt;
                    wide = 64'(instance_total) + 64'(add);
                    instance_total = (wide > 64'hFFFF_FFFF) ? '1 : wide[TOTAL_W-1:0];
                end
            end
            OP_CLEAR:
                instance_total = '0;
            default:
                ;
        endcase
        beat.total = instance_total;
        return beat;
    endfunction

    // watch both channels and the plane writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        cull_beat_t want;
        int         i;
        if (!rst_n)
        begin
            for (i = 0; i < NUM_PLANES; i++)
                plane_regs[i] = '0;
            instance_total = '0;
            expected_beats.delete();
            mismatches    = 0;
            pending_beats = 0;
            checked_beats = 0;
            culled_beats  = 0;
        end
        else
        begin
            // result beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: visible %0d, visible_total %0d",
                           visible, visible_total);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (visible !== want.visible)
                    begin
                        $error("visible: expected %0d, got %0d", want.visible, visible);
                        mismatches++;
                    end
                    if (visible_total !== want.total)
                    begin
                        $error("visible_total: expected %0d, got %0d",
                               want.total, visible_total);
                        mismatches++;
                    end
                    checked_beats++;
                    if (!want.visible)
                        culled_beats++;
                end
            end
            // input beat: predict its result and queue it at the tail
            if (in_valid && !in_stall)
                expected_beats.insert(expected_beats.size(),
                                      cull_item(op, px, py, pz, qx, qy, qz,
                                                radius, item_count));
            // plane write, indexes past the last plane are dropped
            if (cfg_wr_en && cfg_index < NUM_PLANES)
                plane_regs[cfg_index] = cfg_data;
            pending_beats = expected_beats.size();
        end
    end

endmodule

### tb/frustum_box_sphere_cull_test.sv
// frustum_box_sphere_cull_test: stimulus, idling and verdict for the cull unit
`timescale 1ns / 100ps

module frustum_box_sphere_cull_test
    import fbsc_pkg::*;
();

    localparam int CLUSTER_MAX = 128;
    localparam int PHASE_ITEMS = 310;
    localparam int PHASES      = 6;
    localparam int Q_ONE       = 16384;
    localparam int HOLD_CYCLES = 60;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [PLANE_IDX_W-1:0] PLANE_LEFT   = 3'd0;
    localparam logic [PLANE_IDX_W-1:0] PLANE_RIGHT  = 3'd1;
    localparam logic [PLANE_IDX_W-1:0] PLANE_BOTTOM = 3'd2;
    localparam logic [PLANE_IDX_W-1:0] PLANE_TOP    = 3'd3;
    localparam logic [PLANE_IDX_W-1:0] PLANE_NEAR   = 3'd4;
    localparam logic [PLANE_IDX_W-1:0] PLANE_FAR    = 3'd5;
    localparam logic [PLANE_IDX_W-1:0] PLANE_SPARE  = 3'd6;
    localparam logic [PLANE_IDX_W-1:0] PLANE_LAST   = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [PLANE_IDX_W-1:0]     cfg_index;
    logic [PLANE_W-1:0]         cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 op;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic signed [COORD_W-1:0]  qx;
    logic signed [COORD_W-1:0]  qy;
    logic signed [COORD_W-1:0]  qz;
    logic [COORD_W-1:0]         radius;
    logic [COUNT_W-1:0]         item_count;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       visible;
    logic [TOTAL_W-1:0]         visible_total;

    int mismatches;
    int pending_beats;
    int checked_beats;
    int culled_beats;

    int sender_gap_pct;
    int receiver_gap_pct;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // 2 ns clock
    always #1 clk = ~clk;

    frustum_box_sphere_cull #(
        .CLUSTER_MAX (CLUSTER_MAX)
    ) DUT (
        .*
    );

    frustum_box_sphere_cull_checker #(
        .CLUSTER_MAX (CLUSTER_MAX)
    ) u_checker (
        .*
    );

    // run limit
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall, or a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_gap_pct);
    end

    function automatic logic [PLANE_W-1:0] pack_plane(input int nx, input int ny,
                                                      input int nz, input int d);
        return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
    endfunction

    // mostly near the origin, sometimes anywhere
    function automatic logic [COORD_W-1:0] rand_coord();
        int v;
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        v = int'($urandom_range(16000)) - 8000;
        return v[15:0];
    endfunction

    task automatic write_reg(input logic [PLANE_IDX_W-1:0] idx, input logic [PLANE_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // axis-aligned cube of the given half size around the origin
    task automatic load_cube(input int half);
        write_reg(PLANE_LEFT,   pack_plane(Q_ONE, 0, 0, half));
        write_reg(PLANE_RIGHT,  pack_plane(-Q_ONE, 0, 0, half));
        write_reg(PLANE_BOTTOM, pack_plane(0, Q_ONE, 0, half));
        write_reg(PLANE_TOP,    pack_plane(0, -Q_ONE, 0, half));
        write_reg(PLANE_NEAR,   pack_plane(0, 0, Q_ONE, half));
        write_reg(PLANE_FAR,    pack_plane(0, 0, -Q_ONE, half));
    endtask

    // drop valid and wait until every result beat is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one input beat; returns at the accepting edge with valid still high
    task automatic send_item(input logic [1:0] kind,
                             input int ax, ay, az, bx, by, bz,
                             input int rad, input int cnt);
        @(negedge clk);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        op         <= kind;
        px         <= 16'(ax);
        py         <= 16'(ay);
        pz         <= 16'(az);
        qx         <= 16'(bx);
        qy         <= 16'(by);
        qz         <= 16'(bz);
        radius     <= 16'(rad);
        item_count <= 8'(cnt);
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [1:0]          kind;
        int                  ax, ay, az, bx, by, bz, rad;
        int                  cnt;
        int                  pick, phase, n, i;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        op               = OP_BOX;
        px               = '0;
        py               = '0;
        pz               = '0;
        qx               = '0;
        qy               = '0;
        qz               = '0;
        radius           = '0;
        item_count       = '0;
        sender_gap_pct   = 30;
        receiver_gap_pct = 82;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // planes are all zero after reset, so everything passes
        send_item(OP_BOX, -5, -5, -5, 5, 5, 5, 0, 0);
        send_item(OP_SPHERE, 32767, -32768, 0, 0, 0, 0, 0, 128);
        drain();

        // directed items against a cube of half size 1000
        load_cube(1000);
        send_item(OP_BOX, -10, -10, -10, 10, 10, 10, 0, 0);
        send_item(OP_BOX, 1200, 0, 0, 1500, 10, 10, 0, 0);
        send_item(OP_BOX, 1000, 0, 0, 1100, 10, 10, 0, 0);
        send_item(OP_BOX, 1001, 0, 0, 1100, 10, 10, 0, 0);
        send_item(OP_BOX, 500, 500, 500, -500, -500, -500, 0, 0);
        send_item(OP_BOX, 2000, 0, 0, -2000, 0, 0, 0, 0);
        send_item(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 65535, 255);
        send_item(OP_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0, 0);
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 5);
        send_item(OP_SPHERE, -1100, 0, 0, 0, 0, 0, 100, 128);
        send_item(OP_SPHERE, -1101, 0, 0, 0, 0, 0, 100, 50);
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 200);
        send_item(OP_SPHERE, 10, 20, 30, -1, -1, -1, 1, 255);
        send_item(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 65535, 1);
        send_item(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        send_item(OP_SPHERE, 0, 1000, -1000, 32767, -32768, 32767, 0, 0);
        send_item(OP_UNUSED, -1, -1, -1, -1, -1, -1, 65535, 255);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SPHERE, 999, -999, 999, 0, 0, 0, 3, 7);
        send_item(OP_CLEAR, -1, -1, -1, -1, -1, -1, 65535, 255);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            // plane set of this phase
            case (phase)
                0:
                    load_cube($urandom_range(6000, 200));
                1, 4:
                    for (i = 0; i < NUM_PLANES; i++)
                        write_reg(PLANE_IDX_W'(i),
                                  pack_plane(int'($urandom_range(32768)) - Q_ONE,
                                             int'($urandom_range(32768)) - Q_ONE,
                                             int'($urandom_range(32768)) - Q_ONE,
                                             $urandom_range(8000, 500)));
                2:
                    for (i = 0; i < NUM_PLANES; i++)
                        write_reg(PLANE_IDX_W'(i), {$urandom, $urandom});
                3:
                begin
                    write_reg(PLANE_LEFT,   64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(PLANE_RIGHT,  64'h8000_8000_8000_8000);
                    write_reg(PLANE_BOTTOM, 64'h7FFF_7FFF_7FFF_7FFF);
                    write_reg(PLANE_TOP,    64'h7FFF_8000_7FFF_8000);
                    write_reg(PLANE_NEAR,   64'h8000_7FFF_0000_C000);
                    write_reg(PLANE_FAR,    64'h0000_0000_0000_0000);
                    write_reg(PLANE_SPARE,  {$urandom, $urandom});
                    write_reg(PLANE_LAST,   64'hFFFF_FFFF_FFFF_FFFF);
                end
                default:
                begin
                    for (i = 0; i < NUM_PLANES; i++)
                        write_reg(PLANE_IDX_W'(i), '0);
                    write_reg(PLANE_LAST, {$urandom, $urandom});
                end
            endcase

            // idling: sender light and receiver heavy, then swapped, then none
            @(posedge clk);
            sender_gap_pct   = (phase < 2) ? 30 : (phase < 4) ? 82 : 0;
            receiver_gap_pct = (phase < 2) ? 82 : (phase < 4) ? 30 : 0;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long output hold while beats keep coming
                if ((phase == 1 || phase == 4) && n == 100)
                begin
                    hold_requests  = hold_requests + 1;
                    sender_gap_pct = 0;
                end
                if ((phase == 1 || phase == 4) && n == 130)
                    sender_gap_pct = (phase == 1) ? 30 : 0;
                // pause until the block is empty
                if (phase == 2 && n == 150)
                    drain();

                pick = $urandom_range(99);
                kind = (pick < 46) ? OP_BOX : (pick < 92) ? OP_SPHERE :
                       (pick < 97) ? OP_CLEAR : OP_UNUSED;
                ax = int'(rand_coord());
                ay = int'(rand_coord());
                az = int'(rand_coord());
                if ($urandom_range(9) == 0)
                begin
                    bx = int'(16'($urandom));
                    by = int'(16'($urandom));
                    bz = int'(16'($urandom));
                end
                else
                begin
                    bx = ax + int'($urandom_range(3000));
                    by = ay + int'($urandom_range(3000));
                    bz = az + int'($urandom_range(3000));
                end
                rad = ($urandom_range(4) == 0) ? int'(16'($urandom))
                                               : int'($urandom_range(3000));
                cnt = ($urandom_range(4) == 0) ? int'(8'($urandom))
                                               : int'($urandom_range(CLUSTER_MAX));
                send_item(kind, ax, ay, az, bx, by, bz, rad, cnt);
            end
        end

        drain();
        $display("covered %0d result beats (%0d culled) of box, sphere, clear and unused items",
                 checked_beats, culled_beats);
        $display("over zero, cube, tilted, random and extreme plane sets, with stalls and holds");
        if (mismatches == 0 && pending_beats == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/fbsc_pkg.sv
rtl/core/fbsc_plane_test.sv
rtl/core/fbsc_total.sv
rtl/core/frustum_box_sphere_cull.sv
tb/frustum_box_sphere_cull_checker.sv
tb/frustum_box_sphere_cull_test.sv
